// ===== design/rotation_matrix_to_quaternion_defines.svh =====
// Assertion macros shared by the checker of the rotation-matrix-to-quaternion block.
// No dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Check cons in the same cycle as ante.
`define RMQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rmq_pkg.sv =====
// Types and constants of the rotation-matrix-to-quaternion block.
// No dependencies.
`default_nettype none
package rmq_pkg;

  localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

  typedef struct packed {
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } mat_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } quat_t;

endpackage
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion.sv =====
// Top level: transform matrix columns in, normalized quaternion out.
// Depends on rmq_pkg and rmq_unit_vec.
//
// Request channel mat (mat_valid/mat_ready) carries the three basis columns
// right, up and dir as signed Q11.20 (IN_FRAC_BITS fraction bits). Result
// channel quat (quat_valid/quat_ready) carries w, x, y, z as signed Q1.30.
// Each column is normalized (a column of squared length at or below 1e-12 is
// zero), the quaternion is built by the four-branch trace method, and the
// result is normalized; a zero quaternion gives the identity.
// The pipeline has 3 input stages, then the column normalizers, the branch
// select stages and the quaternion normalizer. The long part is the
// one-bit-per-stage square root and divide in each normalizer.
// Throughput is one request per cycle while quat_ready is high.
// Reset clears all valid bits; no result is pending afterwards.
// When quat_ready is low, results hold and stages fill bubble by bubble;
// mat_ready drops only once every stage holds a request.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int IN_FRAC_BITS = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          mat_valid,
  output logic          mat_ready,
  input  rmq_pkg::mat_t mat,
  output logic          quat_valid,
  input  logic          quat_ready,
  output rmq_pkg::quat_t quat
);

  localparam logic [63:0] THR = (64'd1 << (2 * IN_FRAC_BITS)) / 64'd1000000000000;

  logic [3:0] fen;
  logic [2:0] fv;
  logic       cn_ready [3];
  logic       cn_valid [3];

  assign fen[3]    = cn_ready[0] & cn_ready[1] & cn_ready[2];
  assign fen[2]    = ~fv[2] | fen[3];
  assign fen[1]    = ~fv[1] | fen[2];
  assign fen[0]    = ~fv[0] | fen[1];
  assign mat_ready = fen[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      if (fen[0]) fv[0] <= mat_valid;
      if (fen[1]) fv[1] <= fv[0];
      if (fen[2]) fv[2] <= fv[1];
    end
  end

  logic signed [31:0] c0 [3][3], c1 [3][3], c2 [3][3];
  logic [31:0]        mg [3][3];
  logic [63:0]        sq1 [3][3];
  logic               tiny2 [3];

  always_comb begin
    c0[0][0] = mat.right_x; c0[0][1] = mat.right_y; c0[0][2] = mat.right_z;
    c0[1][0] = mat.up_x;    c0[1][1] = mat.up_y;    c0[1][2] = mat.up_z;
    c0[2][0] = mat.dir_x;   c0[2][1] = mat.dir_y;   c0[2][2] = mat.dir_z;
  end

  logic signed [31:0] cr [3][3];

  always_ff @(posedge clk) begin
    if (fen[0]) cr <= c0;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) begin
        mg[c][i] = cr[c][i][31] ? 32'(-cr[c][i]) : 32'(cr[c][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fen[1]) begin
      c1 <= cr;
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          sq1[c][i] <= 64'(mg[c][i]) * 64'(mg[c][i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fen[2]) begin
      c2 <= c1;
      for (int c = 0; c < 3; c++) begin
        tiny2[c] <= (sq1[c][0] + sq1[c][1] + sq1[c][2]) <= THR;
      end
    end
  end

  logic signed [31:0] cu [3][3];
  logic [2:0]         qen;
  logic [1:0]         qv;

  for (genvar c = 0; c < 3; c++) begin : g_col
    rmq_unit_vec #(.N(3), .VW(32)) u_col (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (fv[2]),
      .in_ready  (cn_ready[c]),
      .vec       (c2[c]),
      .blank     (tiny2[c]),
      .out_valid (cn_valid[c]),
      .out_ready (qen[0]),
      .unit      (cu[c]),
      .zero      ()
    );
  end

  logic qn_ready;
  assign qen[2] = qn_ready;
  assign qen[1] = ~qv[1] | qen[2];
  assign qen[0] = ~qv[0] | qen[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= '0;
    end else begin
      if (qen[0]) qv[0] <= cn_valid[0] & cn_valid[1] & cn_valid[2];
      if (qen[1]) qv[1] <= qv[0];
    end
  end

  logic signed [33:0] m [3][3];
  logic signed [33:0] tr0;
  logic               tp0, b00, b10;
  logic signed [33:0] qone;
  logic signed [33:0] qc [4];
  logic signed [33:0] q1 [4];
  logic signed [33:0] rad;

  assign qone = 34'(rmq_pkg::Q_ONE);

  always_ff @(posedge clk) begin
    if (qen[0]) begin
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          m[c][i] <= 34'(cu[c][i]);
        end
      end
      tr0 <= 34'(cu[0][0]) + 34'(cu[1][1]) + 34'(cu[2][2]);
      b00 <= (cu[0][0] > cu[1][1]) && (cu[0][0] > cu[2][2]);
      b10 <= cu[1][1] > cu[2][2];
    end
  end

  assign tp0 = tr0 > 34'sd0;

  // m[c][i] holds column c, row i: m00=m[0][0], m10=m[0][1], m01=m[1][0].
  always_comb begin
    rad = '0;
    if (tp0) begin
      qc[0] = tr0 + qone;
      qc[1] = m[1][2] - m[2][1];
      qc[2] = m[2][0] - m[0][2];
      qc[3] = m[0][1] - m[1][0];
    end else if (b00) begin
      rad   = qone + m[0][0] - m[1][1] - m[2][2];
      qc[0] = m[1][2] - m[2][1];
      qc[1] = rad[33] ? '0 : rad;
      qc[2] = m[1][0] + m[0][1];
      qc[3] = m[2][0] + m[0][2];
    end else if (b10) begin
      rad   = qone + m[1][1] - m[0][0] - m[2][2];
      qc[0] = m[2][0] - m[0][2];
      qc[1] = m[1][0] + m[0][1];
      qc[2] = rad[33] ? '0 : rad;
      qc[3] = m[2][1] + m[1][2];
    end else begin
      rad   = qone + m[2][2] - m[0][0] - m[1][1];
      qc[0] = m[0][1] - m[1][0];
      qc[1] = m[2][0] + m[0][2];
      qc[2] = m[2][1] + m[1][2];
      qc[3] = rad[33] ? '0 : rad;
    end
  end

  always_ff @(posedge clk) begin
    if (qen[1]) q1 <= qc;
  end

  logic signed [31:0] qu [4];
  logic               qz;

  rmq_unit_vec #(.N(4), .VW(34)) u_quat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qv[1]),
    .in_ready  (qn_ready),
    .vec       (q1),
    .blank     (1'b0),
    .out_valid (quat_valid),
    .out_ready (quat_ready),
    .unit      (qu),
    .zero      (qz)
  );

  always_comb begin
    if (qz) begin
      quat.quat_w = rmq_pkg::Q_ONE;
      quat.quat_x = '0;
      quat.quat_y = '0;
      quat.quat_z = '0;
    end else begin
      quat.quat_w = qu[0];
      quat.quat_x = qu[1];
      quat.quat_y = qu[2];
      quat.quat_z = qu[3];
    end
  end

endmodule
`default_nettype wire

// ===== design/rmq_unit_vec.sv =====
// Pipelined vector normalizer: N signed components to Q1.30 unit length.
// Stages: magnitude, max, scale, square, sum, bit-serial square root, restoring divide.
`default_nettype none
module rmq_unit_vec #(
  parameter int N  = 3,
  parameter int VW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VW-1:0] vec [N],
  input  logic                 blank,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   unit [N],
  output logic                 zero
);

  localparam int SQ    = 32;
  localparam int DV    = 31;
  localparam int PW    = $clog2(VW);
  localparam int S_SQ  = 6;
  localparam int S_NUM = S_SQ + SQ;
  localparam int S_DV  = S_NUM + 1;
  localparam int S_OUT = S_DV + DV;
  localparam int D     = S_OUT + 1;

  logic [D:0]   en;
  logic [D-1:0] v;

  assign en[D]     = out_ready;
  assign in_ready  = en[0];
  assign out_valid = v[D-1];

  for (genvar k = 0; k < D; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < D; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  logic [VW-1:0] a0 [N], a1 [N], a2 [N];
  logic [N-1:0]  sg0, sg1, sg2, sg3, sg4, sg5;
  logic          z0, z1, z2, z3, z4, z5;
  logic [VW-1:0] m1, mx;
  logic [PW-1:0] p2, pos;
  logic [30:0]   b3 [N], b4 [N], b5 [N];
  logic [61:0]   sq4 [N];
  logic [63:0]   sum5, sum_c;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < N; i++) begin
        a0[i]  <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
        sg0[i] <= vec[i][VW-1];
      end
      z0 <= blank;
    end
  end

  always_comb begin
    mx = '0;
    for (int i = 0; i < N; i++) begin
      if (a0[i] > mx) mx = a0[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a1  <= a0;
      m1  <= mx;
      sg1 <= sg0;
      z1  <= z0;
    end
  end

  always_comb begin
    pos = '0;
    for (int k = 0; k < VW; k++) begin
      if (m1[k]) pos = PW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a2  <= a1;
      p2  <= pos;
      sg2 <= sg1;
      z2  <= z1 | (m1 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < N; i++) begin
        b3[i] <= 31'(((VW+31)'(a2[i]) << 30) >> p2);
      end
      sg3 <= sg2;
      z3  <= z2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < N; i++) begin
        sq4[i] <= 62'(b3[i] * b3[i]);
      end
      b4  <= b3;
      sg4 <= sg3;
      z4  <= z3;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < N; i++) begin
      sum_c = sum_c + 64'(sq4[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sum5 <= sum_c;
      b5   <= b4;
      sg5  <= sg4;
      z5   <= z4;
    end
  end

  logic [63:0]  sqv [SQ];
  logic [63:0]  sqr [SQ];
  logic [30:0]  sqb [SQ][N];
  logic [N-1:0] sqs [SQ];
  logic         sqz [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]  vin, rin, tr, vnx, rnx;
    logic [30:0]  bin [N];
    logic [N-1:0] sin;
    logic         zin;
    if (k == 0) begin : g_first
      assign vin = sum5;
      assign rin = '0;
      assign bin = b5;
      assign sin = sg5;
      assign zin = z5;
    end else begin : g_next
      assign vin = sqv[k-1];
      assign rin = sqr[k-1];
      assign bin = sqb[k-1];
      assign sin = sqs[k-1];
      assign zin = sqz[k-1];
    end
    always_comb begin
      tr = rin + BIT;
      if (vin >= tr) begin
        vnx = vin - tr;
        rnx = (rin >> 1) + BIT;
      end else begin
        vnx = vin;
        rnx = rin >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en[S_SQ+k]) begin
        sqv[k] <= vnx;
        sqr[k] <= rnx;
        sqb[k] <= bin;
        sqs[k] <= sin;
        sqz[k] <= zin;
      end
    end
  end

  logic [31:0]  nl;
  logic [62:0]  remn [N];
  logic [N-1:0] sgn;
  logic         zn;

  always_ff @(posedge clk) begin
    if (en[S_NUM]) begin
      nl <= sqr[SQ-1][31:0];
      for (int i = 0; i < N; i++) begin
        remn[i] <= (63'(sqb[SQ-1][i]) << 30) + 63'(sqr[SQ-1][31:1]);
      end
      sgn <= sqs[SQ-1];
      zn  <= sqz[SQ-1];
    end
  end

  logic [62:0]  drem [DV][N];
  logic [30:0]  dq   [DV][N];
  logic [31:0]  dl   [DV];
  logic [N-1:0] ds   [DV];
  logic         dz   [DV];

  for (genvar j = 0; j < DV; j++) begin : g_dv
    logic [62:0]  rin [N];
    logic [30:0]  qin [N];
    logic [31:0]  lin;
    logic [N-1:0] sin;
    logic         zin;
    logic [62:0]  dd;
    if (j == 0) begin : g_first
      assign rin = remn;
      assign lin = nl;
      assign sin = sgn;
      assign zin = zn;
      for (genvar i = 0; i < N; i++) begin : g_q0
        assign qin[i] = '0;
      end
    end else begin : g_next
      assign rin = drem[j-1];
      assign qin = dq[j-1];
      assign lin = dl[j-1];
      assign sin = ds[j-1];
      assign zin = dz[j-1];
    end
    assign dd = 63'(lin) << (30 - j);
    always_ff @(posedge clk) begin
      if (en[S_DV+j]) begin
        for (int i = 0; i < N; i++) begin
          if (rin[i] >= dd) begin
            drem[j][i] <= rin[i] - dd;
            dq[j][i]   <= qin[i] | (31'd1 << (30 - j));
          end else begin
            drem[j][i] <= rin[i];
            dq[j][i]   <= qin[i];
          end
        end
        dl[j] <= lin;
        ds[j] <= sin;
        dz[j] <= zin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      for (int i = 0; i < N; i++) begin
        if (dz[DV-1]) begin
          unit[i] <= '0;
        end else if (ds[DV-1][i]) begin
          unit[i] <= -$signed({1'b0, dq[DV-1][i]});
        end else begin
          unit[i] <= $signed({1'b0, dq[DV-1][i]});
        end
      end
      zero <= dz[DV-1];
    end
  end

endmodule
`default_nettype wire

// ===== design/rmq_check.sv =====
// Port-level checker for the rotation-matrix-to-quaternion block, with its bind.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_defines.svh.
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_check (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           quat_valid,
  input wire logic           quat_ready,
  input wire rmq_pkg::quat_t quat
);

  localparam logic signed [31:0] QMAX = rmq_pkg::Q_ONE;

  logic stall, range_ok, nonzero;

  assign stall    = quat_valid && !quat_ready;
  assign range_ok = (quat.quat_w >= -QMAX) && (quat.quat_w <= QMAX) &&
                    (quat.quat_x >= -QMAX) && (quat.quat_x <= QMAX) &&
                    (quat.quat_y >= -QMAX) && (quat.quat_y <= QMAX) &&
                    (quat.quat_z >= -QMAX) && (quat.quat_z <= QMAX);
  assign nonzero  = (quat != '0);

  `RMQ_ASSERT_NEXT(a_hold, clk, rst, stall, quat_valid && $stable(quat), "stalled result changed")
  `RMQ_ASSERT_NOW(a_range, clk, rst, quat_valid, range_ok, "component out of Q1.30 unit range")
  `RMQ_ASSERT_NOW(a_nonzero, clk, rst, quat_valid, nonzero, "zero quaternion delivered")
  `RMQ_ASSERT_NOW(a_reset, clk, rst, $past(rst), !quat_valid, "result valid right after reset")

endmodule

bind rotation_matrix_to_quaternion rmq_check u_check (
  .clk        (clk),
  .rst        (rst),
  .quat_valid (quat_valid),
  .quat_ready (quat_ready),
  .quat       (quat)
);
`default_nettype wire

// ===== tb/rmq_checker.sv =====
// Checker for rotation_matrix_to_quaternion: watches both channels, predicts each
// quaternion from the accepted matrix and compares field by field. Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_checker #(
  parameter int IN_FRAC_BITS = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           mat_valid,
  input  logic           mat_ready,
  input  rmq_pkg::mat_t  mat,
  input  logic           quat_valid,
  input  logic           quat_ready,
  input  rmq_pkg::quat_t quat,
  output int             errors,
  output int             pending
);

  rmq_pkg::quat_t quat_q[$];

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Scale to unit length in Q1.30; returns 0 when the vector is zero.
  function automatic bit scale_unit(input longint v[4], input int n, output longint o[4]);
    logic [63:0] a[4];
    logic [63:0] m, s, len;
    m = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = i < n ? mag(v[i]) : 0;
      if (a[i] > m) m = a[i];
      o[i] = 0;
    end
    if (m == 0) return 0;
    while (m >= 64'h8000_0000) begin
      m = m >> 1;
      for (int i = 0; i < 4; i++) a[i] = a[i] >> 1;
    end
    while (m < 64'h4000_0000) begin
      m = m << 1;
      for (int i = 0; i < 4; i++) a[i] = a[i] << 1;
    end
    for (int i = 0; i < n; i++) s = s + a[i] * a[i];
    len = root64(s);
    for (int i = 0; i < n; i++) begin
      o[i] = longint'(((a[i] << 30) + (len >> 1)) / len);
      if (v[i] < 0) o[i] = -o[i];
    end
    return 1;
  endfunction

  function automatic void unit_column(input logic signed [31:0] x, y, z,
                                      output longint c[4]);
    longint v[4];
    logic [63:0] s, thr;
    v = '{longint'(x), longint'(y), longint'(z), 0};
    s = mag(v[0]) * mag(v[0]) + mag(v[1]) * mag(v[1]) + mag(v[2]) * mag(v[2]);
    thr = (64'd1 << (2 * IN_FRAC_BITS)) / 64'd1000000000000;
    c = '{0, 0, 0, 0};
    if (s > thr) void'(scale_unit(v, 3, c));
  endfunction

  function automatic rmq_pkg::quat_t matrix_to_quat(rmq_pkg::mat_t m);
    longint r[4], u[4], d[4], q[4], qn[4];
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, t, rad, one;
    rmq_pkg::quat_t res;
    one = longint'(rmq_pkg::Q_ONE);
    unit_column(m.right_x, m.right_y, m.right_z, r);
    unit_column(m.up_x, m.up_y, m.up_z, u);
    unit_column(m.dir_x, m.dir_y, m.dir_z, d);
    m00 = r[0]; m10 = r[1]; m20 = r[2];
    m01 = u[0]; m11 = u[1]; m21 = u[2];
    m02 = d[0]; m12 = d[1]; m22 = d[2];
    t = m00 + m11 + m22;
    if (t > 0) begin
      q = '{t + one, m21 - m12, m02 - m20, m10 - m01};
    end else if (m00 > m11 && m00 > m22) begin
      rad = one + m00 - m11 - m22;
      q = '{m21 - m12, rad < 0 ? 0 : rad, m01 + m10, m02 + m20};
    end else if (m11 > m22) begin
      rad = one + m11 - m00 - m22;
      q = '{m02 - m20, m01 + m10, rad < 0 ? 0 : rad, m12 + m21};
    end else begin
      rad = one + m22 - m00 - m11;
      q = '{m10 - m01, m02 + m20, m12 + m21, rad < 0 ? 0 : rad};
    end
    if (!scale_unit(q, 4, qn)) qn = '{one, 0, 0, 0};
    res.quat_w = qn[0][31:0];
    res.quat_x = qn[1][31:0];
    res.quat_y = qn[2][31:0];
    res.quat_z = qn[3][31:0];
    return res;
  endfunction

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    rmq_pkg::quat_t want;
    if (rst) begin
      errors = 0;
    end else begin
      if (mat_valid && mat_ready) quat_q.push_back(matrix_to_quat(mat));
      if (quat_valid && quat_ready) begin
        if (quat_q.size() == 0) begin
          report("unexpected quaternion");
        end else begin
          want = quat_q.pop_front();
          if (quat.quat_w !== want.quat_w)
            report($sformatf("quat_w got %0d expected %0d", quat.quat_w, want.quat_w));
          if (quat.quat_x !== want.quat_x)
            report($sformatf("quat_x got %0d expected %0d", quat.quat_x, want.quat_x));
          if (quat.quat_y !== want.quat_y)
            report($sformatf("quat_y got %0d expected %0d", quat.quat_y, want.quat_y));
          if (quat.quat_z !== want.quat_z)
            report($sformatf("quat_z got %0d expected %0d", quat.quat_z, want.quat_z));
        end
      end
    end
    pending = quat_q.size();
  end
endmodule

// ===== tb/rotation_matrix_to_quaternion_tb.sv =====
// Testbench top for rotation_matrix_to_quaternion: drives matrix requests with random
// idling and backpressure, and gives the verdict. Depends on rmq_pkg and rmq_checker.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;

  localparam int LATENCY = 147;
  localparam int N_RAND = 640;
  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic mat_valid = 0;
  logic mat_ready;
  rmq_pkg::mat_t mat = '0;
  logic quat_valid;
  logic quat_ready = 0;
  rmq_pkg::quat_t quat;
  int errors, pending;
  bit sink_idle = 1;
  bit long_hold = 0;
  bit stim_done = 0;
  int quiet = 0;
  int sink_hold = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rotation_matrix_to_quaternion u_top (
    .clk(clk), .rst(rst), .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
    .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat)
  );

  rmq_checker u_chk (
    .clk(clk), .rst(rst), .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
    .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
    .errors(errors), .pending(pending)
  );

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3) - 1;
      3: return 32'($signed($urandom_range(0, 4096)) - 2048);
      4: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
      default: return $urandom();
    endcase
  endfunction

  // Rotation-like matrix: scaled signed permutation with small noise.
  function automatic rmq_pkg::mat_t rand_rot();
    logic [31:0] c[9];
    int p[3];
    int s;
    p = '{0, 1, 2};
    p.shuffle();
    s = $urandom_range(1, 1 << 22);
    foreach (c[i]) c[i] = 32'($signed($urandom_range(0, 2 * (s >> 3))) - (s >> 3));
    for (int k = 0; k < 3; k++) c[3 * k + p[k]] = $urandom_range(0, 1) ? s : -s;
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
  endfunction

  task automatic send(rmq_pkg::mat_t m);
    mat <= m;
    mat_valid <= 1;
    do @(posedge clk); while (!mat_ready);
  endtask

  task automatic gap();
    mat_valid <= 0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || long_hold) begin
      quat_ready <= 0;
      sink_hold <= 0;
    end else if (stim_done || !sink_idle) begin
      quat_ready <= 1;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      quat_ready <= 0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      quat_ready <= 0;
      sink_hold <= int'($urandom_range(0, 11));
    end else begin
      quat_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst) quiet <= 0;
    else if ((mat_valid && mat_ready) || (quat_valid && quat_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
    end
  end

  initial begin
    rmq_pkg::mat_t m;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send('0);
    send({9{32'h8000_0000}});
    send({9{32'h7fff_ffff}});
    send({32'd1 << 20, 32'd0, 32'd0, 32'd0, 32'd1 << 20, 32'd0, 32'd0, 32'd0, 32'd1 << 20});
    send({-32'sd1048576, 32'd0, 32'd0, 32'd0, 32'd1 << 20, 32'd0, 32'd0, 32'd0,
          -32'sd1048576});
    send({32'd1 << 20, 32'd0, 32'd0, 32'd0, -32'sd1048576, 32'd0, 32'd0, 32'd0,
          -32'sd1048576});
    send({-32'sd1048576, 32'd0, 32'd0, 32'd0, -32'sd1048576, 32'd0, 32'd0, 32'd0,
          32'd1 << 20});
    send({-32'sd1048576, 32'd0, 32'd0, 32'd0, -32'sd1048576, 32'd0, 32'd0, 32'd0,
          -32'sd1048576});
    send({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
    send({32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd3});
    send({32'h8000_0000, 32'h7fff_ffff, 32'd5, 32'd0, 32'd0, 32'd0,
          32'd0, 32'h8000_0000, 32'd0});
    mat_valid <= 0;
    wait (pending == 0);
    repeat (LATENCY) @(posedge clk);
    long_hold <= 1;
    fork
      repeat (400) @(posedge clk);
      for (int i = 0; i < 300; i++) begin
        send(rand_rot());
        if (!long_hold) break;
      end
    join_any
    long_hold <= 0;
    wait fork;
    mat_valid <= 0;
    for (int i = 0; i < N_RAND; i++) begin
      if (i < N_RAND * 3 / 4) begin
        sink_idle <= 1;
        if ($urandom_range(0, 7) == 0) gap();
      end else begin
        sink_idle <= 0;
      end
      if ($urandom_range(0, 3) != 0) m = rand_rot();
      else m = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      send(m);
    end
    mat_valid <= 0;
    stim_done <= 1;
    wait (pending == 0);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("rotation_matrix_to_quaternion verification clean");
    end else begin
      $display("rotation_matrix_to_quaternion verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/rmq_pkg.sv
design/rmq_unit_vec.sv
design/rotation_matrix_to_quaternion.sv
design/rmq_check.sv
tb/rmq_checker.sv
tb/rotation_matrix_to_quaternion_tb.sv
